FILE: rtl/char_lcd_write_sequencer_assert.svh
`ifndef CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define CLWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check an implication with the consequent in the following cycle.
`define CLWS_ASSERT_NEXT(label, pre, post, msg) \
  `CLWS_ASSERT(label, (pre) |=> (post), msg)

`endif

FILE: rtl/clws_pkg.sv
package clws_pkg;

  typedef enum logic [1:0] {
    ACT_CHAR  = 2'd0,
    ACT_GLYPH = 2'd1,
    ACT_INIT  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_FOUR_BIT   = 2'd0,
    REG_FUNC_SET   = 2'd1,
    REG_ENTRY_MODE = 2'd2,
    REG_DISP_MODE  = 2'd3
  } reg_e;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_CGRAM   = 8'h40;
  localparam logic [7:0] CMD_DDRAM   = 8'h80;
  localparam logic [7:0] ROW1_OFFSET = 8'h40;

  localparam logic [4:0] HOLD_LONG    = 5'd10;
  localparam logic [4:0] HOLD_CMD_ON  = 5'd1;
  localparam logic [4:0] HOLD_CMD_OFF = 5'd5;
  localparam logic [4:0] HOLD_SETTLE  = 5'd10;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  localparam logic        RST_FOUR_BIT   = 1'b1;
  localparam logic [7:0]  RST_FUNC_SET   = 8'd40;
  localparam logic [7:0]  RST_ENTRY_MODE = 8'd6;
  localparam logic [7:0]  RST_DISP_MODE  = 8'd12;

  typedef struct packed {
    logic            capture;
    logic            load;
    logic [IdxW-1:0] byte_idx;
    logic [1:0]      phase_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic byte_end;
    logic item_end;
  } dp_status_t;

endpackage

FILE: rtl/clws_ctrl.sv
module clws_ctrl
  import clws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] byte_idx_q, byte_idx_d;
  logic [1:0]      phase_idx_q, phase_idx_d;
  logic            capture, load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign capture     = in_valid_i && in_ready_o;
  assign load        = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  assign cmd_o.capture   = capture;
  assign cmd_o.load      = load;
  assign cmd_o.byte_idx  = byte_idx_q;
  assign cmd_o.phase_idx = phase_idx_q;

  always_comb begin
    state_d     = state_q;
    byte_idx_d  = byte_idx_q;
    phase_idx_d = phase_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (capture) begin
          state_d     = ST_EMIT;
          byte_idx_d  = '0;
          phase_idx_d = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          priority if (status_i.item_end) begin
            state_d = ST_IDLE;
          end else if (status_i.byte_end) begin
            byte_idx_d  = byte_idx_q + 1'b1;
            phase_idx_d = '0;
          end else begin
            phase_idx_d = phase_idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      byte_idx_q  <= '0;
      phase_idx_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      byte_idx_q  <= byte_idx_d;
      phase_idx_q <= phase_idx_d;
    end
  end

`include "char_lcd_write_sequencer_assert.svh"

  `CLWS_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `CLWS_ASSERT_NEXT(a_capture_emit, capture, state_q == ST_EMIT, "capture did not start emit")
  `CLWS_ASSERT_NEXT(a_end_idle, load && status_i.item_end, in_ready_o, "no idle after last phase")
  `CLWS_ASSERT_NEXT(a_load_valid, load, out_valid_q, "loaded phase not presented")

endmodule

FILE: rtl/clws_dp.sv
module clws_dp
  import clws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  logic       four_bit_i,
  input  logic [7:0] func_set_i,
  input  logic [7:0] entry_mode_i,
  input  logic [7:0] disp_mode_i,
  input  logic [1:0] action_i,
  input  logic [7:0] char_code_i,
  input  logic [1:0] row_i,
  input  logic [5:0] column_i,
  input  logic [2:0] glyph_index_i,
  input  logic [2:0] glyph_row_i,
  output logic       reg_select_o,
  output logic       read_write_o,
  output logic       enable_pin_o,
  output logic [7:0] data_pins_o,
  output logic [4:0] hold_units_o,
  output logic       last_phase_o
);

  logic [7:0]      bytes_q [MaxBytes];
  logic [7:0]      bytes_d [MaxBytes];
  logic [MaxBytes-1:0] is_data_q, is_data_d;
  logic            settle_q, settle_d;
  logic [IdxW-1:0] last_idx_q, last_idx_d;

  logic       rs_q, en_q, last_q;
  logic [7:0] pins_q;
  logic [4:0] hold_q;

  logic [7:0] cur_byte, cur_pins;
  logic       cur_data, cur_en;
  logic [4:0] cur_hold;
  logic [7:0] ddram_addr, cgram_addr;

  assign ddram_addr = (row_i[0] ? (CMD_DDRAM + ROW1_OFFSET) : CMD_DDRAM) + {2'b00, column_i};
  assign cgram_addr = CMD_CGRAM + {2'b00, glyph_index_i, 3'b000} + {5'b00000, glyph_row_i};

  always_comb begin
    for (int i = 0; i < MaxBytes; i++) begin
      bytes_d[i] = '0;
    end
    is_data_d  = '0;
    settle_d   = 1'b0;
    last_idx_d = '0;
    unique case (action_e'(action_i))
      ACT_CHAR: begin
        if (row_i[1]) begin
          bytes_d[0]   = char_code_i;
          is_data_d[0] = 1'b1;
        end else begin
          bytes_d[0]   = ddram_addr;
          bytes_d[1]   = char_code_i;
          is_data_d[1] = 1'b1;
          last_idx_d   = IdxW'(1);
        end
      end
      ACT_GLYPH: begin
        bytes_d[0]   = cgram_addr;
        bytes_d[1]   = char_code_i;
        is_data_d[1] = 1'b1;
        last_idx_d   = IdxW'(1);
      end
      ACT_INIT: begin
        bytes_d[0] = func_set_i;
        bytes_d[1] = entry_mode_i;
        bytes_d[2] = disp_mode_i;
        bytes_d[3] = CMD_CLEAR;
        settle_d   = 1'b1;
        last_idx_d = IdxW'(3);
      end
      ACT_CLEAR: begin
        bytes_d[0] = CMD_CLEAR;
        bytes_d[1] = CMD_HOME;
        settle_d   = 1'b1;
        last_idx_d = IdxW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    cur_byte = bytes_q[cmd_i.byte_idx];
    cur_data = is_data_q[cmd_i.byte_idx];
    cur_en   = ~cmd_i.phase_idx[0];
    if (four_bit_i) begin
      cur_pins = cmd_i.phase_idx[1] ? {cur_byte[3:0], 4'b0000} : {cur_byte[7:4], 4'b0000};
    end else begin
      cur_pins = cur_byte;
    end
    priority if (four_bit_i && !cmd_i.phase_idx[1]) begin
      cur_hold = HOLD_LONG;
    end else if (cur_en) begin
      cur_hold = cur_data ? HOLD_LONG : HOLD_CMD_ON;
    end else begin
      cur_hold = (cur_data ? HOLD_LONG : HOLD_CMD_OFF) + (settle_q ? HOLD_SETTLE : 5'd0);
    end
  end

  assign status_o.byte_end = four_bit_i ? (cmd_i.phase_idx == 2'd3) : cmd_i.phase_idx[0];
  assign status_o.item_end = status_o.byte_end && (cmd_i.byte_idx == last_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= '0;
    end else if (cmd_i.capture) begin
      last_idx_q <= last_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      bytes_q   <= bytes_d;
      is_data_q <= is_data_d;
      settle_q  <= settle_d;
    end
    if (cmd_i.load) begin
      rs_q   <= cur_data;
      en_q   <= cur_en;
      pins_q <= cur_pins;
      hold_q <= cur_hold;
      last_q <= status_o.item_end;
    end
  end

  assign reg_select_o = rs_q;
  assign read_write_o = 1'b0;
  assign enable_pin_o = en_q;
  assign data_pins_o  = pins_q;
  assign hold_units_o = hold_q;
  assign last_phase_o = last_q;

endmodule

FILE: rtl/char_lcd_write_sequencer.sv
// Character-LCD write sequencer: each request (write character, write glyph row,
// initialize, clear) unrolls into 2 to 16 pin phases (RS, RW, E, data pins, hold
// time in delay units), one phase per cycle on the output stream while m_axis_tready
// does not stall it, tlast on the final one. The next request is taken once the
// last phase sits in the output register. Hold times are only reported, a
// downstream timer applies them. Configure only while no request is in flight.
module char_lcd_write_sequencer
  import clws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code, row, column, glyph_index, glyph_row, pad
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // read_write, enable_pin, data_pins, hold_units, pad
  output logic        m_axis_tuser,  // reg_select
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       four_bit_q;
  logic [7:0] func_set_q, entry_mode_q, disp_mode_q;
  logic       cfg_we;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic       read_write, enable_pin;
  logic [7:0] data_pins;
  logic [4:0] hold_units;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q   <= RST_FOUR_BIT;
      func_set_q   <= RST_FUNC_SET;
      entry_mode_q <= RST_ENTRY_MODE;
      disp_mode_q  <= RST_DISP_MODE;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[3:2]))
        REG_FOUR_BIT:   four_bit_q   <= pwdata[0];
        REG_FUNC_SET:   func_set_q   <= pwdata[7:0];
        REG_ENTRY_MODE: entry_mode_q <= pwdata[7:0];
        REG_DISP_MODE:  disp_mode_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_FOUR_BIT:   prdata = {31'd0, four_bit_q};
      REG_FUNC_SET:   prdata = {24'd0, func_set_q};
      REG_ENTRY_MODE: prdata = {24'd0, entry_mode_q};
      REG_DISP_MODE:  prdata = {24'd0, disp_mode_q};
      default:        prdata = '0;
    endcase
  end

  clws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clws_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .four_bit_i    (four_bit_q),
    .func_set_i    (func_set_q),
    .entry_mode_i  (entry_mode_q),
    .disp_mode_i   (disp_mode_q),
    .action_i      (s_axis_tuser),
    .char_code_i   (s_axis_tdata[7:0]),
    .row_i         (s_axis_tdata[9:8]),
    .column_i      (s_axis_tdata[15:10]),
    .glyph_index_i (s_axis_tdata[18:16]),
    .glyph_row_i   (s_axis_tdata[21:19]),
    .reg_select_o  (m_axis_tuser),
    .read_write_o  (read_write),
    .enable_pin_o  (enable_pin),
    .data_pins_o   (data_pins),
    .hold_units_o  (hold_units),
    .last_phase_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, hold_units, data_pins, enable_pin, read_write};

endmodule

FILE: tb/sv/char_lcd_write_sequencer_tb.sv
`timescale 1ns / 100ps

module char_lcd_write_sequencer_tb;
  import clws_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    action_e    act;
    logic [7:0] code;
    logic [1:0] row;
    logic [5:0] col;
    logic [2:0] gidx;
    logic [2:0] grow;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [7:0] data;
    logic [4:0] hold;
    logic       last;
  } pin_phase_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // char_code, row, column, glyph_index, glyph_row, pad
  logic [1:0]  s_axis_tuser = '0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // read_write, enable_pin, data_pins, hold_units, pad
  logic        m_axis_tuser;       // reg_select
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lcd_req_t   req_q[$];
  pin_phase_t pin_phase_q[$];

  logic       cfg_nibble = RST_FOUR_BIT;
  logic [7:0] cfg_func   = RST_FUNC_SET;
  logic [7:0] cfg_entry  = RST_ENTRY_MODE;
  logic [7:0] cfg_disp   = RST_DISP_MODE;

  bit          no_idle = 1'b0;
  bit          rx_hold = 1'b0;
  bit          req_taken = 1'b0;
  int unsigned n_taken = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  lcd_req_t    next_req;

  char_lcd_write_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void add_pin_phase(logic rs, logic en, logic [7:0] data, logic [4:0] hold);
    pin_phase_t p;
    p.rs   = rs;
    p.rw   = 1'b0;
    p.en   = en;
    p.data = data;
    p.hold = hold;
    p.last = 1'b0;
    pin_phase_q.push_back(p);
  endfunction

  function automatic void add_lcd_byte(logic [7:0] b, logic is_data, logic settle);
    logic [4:0] on_hold;
    logic [4:0] off_hold;
    on_hold  = is_data ? 5'd10 : 5'd1;
    off_hold = (is_data ? 5'd10 : 5'd5) + (settle ? 5'd10 : 5'd0);
    if (cfg_nibble) begin
      add_pin_phase(is_data, 1'b1, {b[7:4], 4'h0}, 5'd10);
      add_pin_phase(is_data, 1'b0, {b[7:4], 4'h0}, 5'd10);
      add_pin_phase(is_data, 1'b1, {b[3:0], 4'h0}, on_hold);
      add_pin_phase(is_data, 1'b0, {b[3:0], 4'h0}, off_hold);
    end else begin
      add_pin_phase(is_data, 1'b1, b, on_hold);
      add_pin_phase(is_data, 1'b0, b, off_hold);
    end
  endfunction

  function automatic void unroll_request(lcd_req_t r);
    case (r.act)
      ACT_CHAR: begin
        if (r.row == 2'd0) begin
          add_lcd_byte(CMD_DDRAM + 8'(r.col), 1'b0, 1'b0);
        end else if (r.row == 2'd1) begin
          add_lcd_byte(CMD_DDRAM + ROW1_OFFSET + 8'(r.col), 1'b0, 1'b0);
        end
        add_lcd_byte(r.code, 1'b1, 1'b0);
      end
      ACT_GLYPH: begin
        add_lcd_byte(CMD_CGRAM + {2'b00, r.gidx, 3'b000} + 8'(r.grow), 1'b0, 1'b0);
        add_lcd_byte(r.code, 1'b1, 1'b0);
      end
      ACT_INIT: begin
        add_lcd_byte(cfg_func, 1'b0, 1'b1);
        add_lcd_byte(cfg_entry, 1'b0, 1'b1);
        add_lcd_byte(cfg_disp, 1'b0, 1'b1);
        add_lcd_byte(CMD_CLEAR, 1'b0, 1'b1);
      end
      default: begin
        add_lcd_byte(CMD_CLEAR, 1'b0, 1'b1);
        add_lcd_byte(CMD_HOME, 1'b0, 1'b1);
      end
    endcase
    pin_phase_q[pin_phase_q.size() - 1].last = 1'b1;
  endfunction

  function automatic lcd_req_t make_req(action_e act, logic [7:0] code, logic [1:0] row,
                                        logic [5:0] col, logic [2:0] gidx, logic [2:0] grow);
    lcd_req_t r;
    r.act  = act;
    r.code = code;
    r.row  = row;
    r.col  = col;
    r.gidx = gidx;
    r.grow = grow;
    return r;
  endfunction

  function automatic lcd_req_t random_req();
    return make_req(action_e'($urandom_range(3)), 8'($urandom), 2'($urandom),
                    6'($urandom), 3'($urandom), 3'($urandom));
  endfunction

  task automatic queue_directed();
    req_q.push_back(make_req(ACT_CHAR, 8'h00, 2'd0, 6'd0, 3'd0, 3'd0));
    req_q.push_back(make_req(ACT_CHAR, 8'hFF, 2'd0, 6'd63, 3'd7, 3'd7));
    req_q.push_back(make_req(ACT_CHAR, 8'hA5, 2'd1, 6'd0, 3'd0, 3'd0));
    req_q.push_back(make_req(ACT_CHAR, 8'h5A, 2'd1, 6'd63, 3'd0, 3'd0));
    req_q.push_back(make_req(ACT_CHAR, 8'h41, 2'd2, 6'd17, 3'd0, 3'd0));
    req_q.push_back(make_req(ACT_CHAR, 8'hFF, 2'd3, 6'd63, 3'd7, 3'd7));
    req_q.push_back(make_req(ACT_CHAR, 8'h00, 2'd3, 6'd0, 3'd0, 3'd0));
    req_q.push_back(make_req(ACT_GLYPH, 8'h00, 2'd0, 6'd0, 3'd0, 3'd0));
    req_q.push_back(make_req(ACT_GLYPH, 8'hFF, 2'd3, 6'd63, 3'd7, 3'd7));
    req_q.push_back(make_req(ACT_GLYPH, 8'h1F, 2'd0, 6'd0, 3'd3, 3'd4));
    req_q.push_back(make_req(ACT_INIT, 8'h00, 2'd0, 6'd0, 3'd0, 3'd0));
    req_q.push_back(make_req(ACT_CLEAR, 8'h00, 2'd0, 6'd0, 3'd0, 3'd0));
    req_q.push_back(make_req(ACT_INIT, 8'hFF, 2'd3, 6'd63, 3'd7, 3'd7));
    req_q.push_back(make_req(ACT_CLEAR, 8'hFF, 2'd3, 6'd63, 3'd7, 3'd7));
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) req_q.push_back(random_req());
  endtask

  task automatic cfg_write(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FOUR_BIT:   cfg_nibble = value[0];
      REG_FUNC_SET:   cfg_func   = value[7:0];
      REG_ENTRY_MODE: cfg_entry  = value[7:0];
      default:        cfg_disp   = value[7:0];
    endcase
  endtask

  task automatic cfg_all(logic nibble, logic [7:0] func, logic [7:0] entry, logic [7:0] disp);
    cfg_write(REG_FOUR_BIT, {31'd0, nibble});
    cfg_write(REG_FUNC_SET, {24'd0, func});
    cfg_write(REG_ENTRY_MODE, {24'd0, entry});
    cfg_write(REG_DISP_MODE, {24'd0, disp});
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || s_axis_tvalid || pin_phase_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // feed requests
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (req_q.size() != 0 && (no_idle || $urandom_range(99) >= 24)) begin
        next_req = req_q.pop_front();
        s_axis_tdata  <= {2'b00, next_req.grow, next_req.gidx, next_req.col,
                          next_req.row, next_req.code};
        s_axis_tuser  <= next_req.act;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 24);
    end
  end

  // check phases, then predict from the request taken at this edge
  always @(posedge clk_i) begin
    pin_phase_t got;
    pin_phase_t want;
    lcd_req_t   seen;
    if (m_axis_tvalid && m_axis_tready) begin
      got.rs   = m_axis_tuser;
      got.rw   = m_axis_tdata[0];
      got.en   = m_axis_tdata[1];
      got.data = m_axis_tdata[9:2];
      got.hold = m_axis_tdata[14:10];
      got.last = m_axis_tlast;
      if (pin_phase_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports) begin
          $display("unexpected phase: rs=%0d rw=%0d en=%0d data=%02h hold=%0d last=%0d",
                   got.rs, got.rw, got.en, got.data, got.hold, got.last);
        end
      end else begin
        want = pin_phase_q.pop_front();
        if (got.rs != want.rs || got.rw != want.rw || got.en != want.en ||
            got.data != want.data || got.hold != want.hold || got.last != want.last) begin
          n_errors++;
          if (n_errors <= MaxReports) begin
            $display("phase mismatch: exp rs=%0d rw=%0d en=%0d data=%02h hold=%0d last=%0d",
                     want.rs, want.rw, want.en, want.data, want.hold, want.last);
            $display("                got rs=%0d rw=%0d en=%0d data=%02h hold=%0d last=%0d",
                     got.rs, got.rw, got.en, got.data, got.hold, got.last);
          end
        end
      end
    end
    req_taken = s_axis_tvalid && s_axis_tready;
    if (req_taken) begin
      seen = make_req(action_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[9:8],
                      s_axis_tdata[15:10], s_axis_tdata[18:16], s_axis_tdata[21:19]);
      unroll_request(seen);
      n_taken++;
    end
  end

  // hold off the receiver so the block backs up
  initial begin
    wait (n_taken >= 70);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    queue_directed();
    wait_drained();

    cfg_all(1'b0, 8'hFF, 8'h00, 8'hA5);
    queue_directed();
    queue_random(40);
    wait_drained();

    no_idle = 1'b1;
    cfg_all(1'b1, 8'h00, 8'hFF, 8'h5A);
    queue_random(40);
    wait_drained();
    no_idle = 1'b0;

    cfg_all(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    queue_random(36);
    wait_drained();

    cfg_all(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    queue_random(36);
    wait_drained();

    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/clws_pkg.sv
rtl/clws_ctrl.sv
rtl/clws_dp.sv
rtl/char_lcd_write_sequencer.sv
tb/sv/char_lcd_write_sequencer_tb.sv
